// ===== sv/lcat_pkg.sv =====
// shared constants for the toroidal life cell store
`default_nettype none
package lcat_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 64;
    localparam int unsigned DEF_MAX_HEIGHT = 64;
    localparam int unsigned SIZE_RESET     = 64;

    localparam int unsigned CFG_BITS   = 7;
    localparam int unsigned COORD_BITS = 6;
    localparam int unsigned CELL_BITS  = 2;
    localparam int unsigned CNT_BITS   = 4;

    // action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_STEP  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // cell bit layout
    localparam int unsigned ALIVE_POS   = 0;
    localparam int unsigned CHANGED_POS = 1;
    localparam logic [CELL_BITS-1:0] CELL_DEAD          = 2'b00;
    localparam logic [CELL_BITS-1:0] CELL_CHANGED       = 2'b10;
    localparam logic [CELL_BITS-1:0] CELL_ALIVE_CHANGED = 2'b11;

    // neighbour offset codes
    localparam logic [1:0] OFS_MINUS = 2'd0;
    localparam logic [1:0] OFS_ZERO  = 2'd1;
    localparam logic [1:0] OFS_PLUS  = 2'd2;

    localparam int unsigned NB_COUNT = 8;

    // neighbour k sits at bits [2k+1:2k]; order row above, same row, row below
    localparam logic [2*NB_COUNT-1:0] NB_DX = {OFS_PLUS, OFS_ZERO, OFS_MINUS,
                                               OFS_PLUS, OFS_MINUS,
                                               OFS_PLUS, OFS_ZERO, OFS_MINUS};
    localparam logic [2*NB_COUNT-1:0] NB_DY = {OFS_PLUS, OFS_PLUS, OFS_PLUS,
                                               OFS_ZERO, OFS_ZERO,
                                               OFS_MINUS, OFS_MINUS, OFS_MINUS};

    // b3/s23 rule
    localparam logic [CNT_BITS-1:0] BORN_COUNT  = 4'd3;
    localparam logic [CNT_BITS-1:0] SURVIVE_MIN = 4'd2;
    localparam logic [CNT_BITS-1:0] SURVIVE_MAX = 4'd3;

endpackage
`default_nettype wire

// ===== sv/life_cellular_automaton_torus_top.sv =====
// toroidal b3/s23 life cell store with write, read, step and clear actions
// write and read take x modulo grid_width and y modulo grid_height (wrap by subtraction)
// step: 8 neighbour reads per cell through one ram port, then one read and one write
//   per cell; clear: one write per cell of the whole store
// one item at a time; a finished beat may wait at the output while the next item is accepted
// reset: async active low; then a pass over every cell of the store clears the grid, s_tready low
`default_nettype none
module life_cellular_automaton_torus_top
    import lcat_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // cell_x[5:0], cell_y[11:6], tile_value[13:12], zero
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // cell_alive[0], cell_changed[1], zero
    output logic      [1:0]  m_tuser,   // done_action[1:0]
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int unsigned XA    = $clog2(MAX_WIDTH);
    localparam int unsigned YA    = $clog2(MAX_HEIGHT);
    localparam int unsigned XW    = $clog2(MAX_WIDTH + 1);
    localparam int unsigned YW    = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned MW0   = (XW > YW) ? XW : YW;
    localparam int unsigned MW    = (MW0 > COORD_BITS) ? MW0 : COORD_BITS;
    localparam int unsigned W_RST = (SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : SIZE_RESET;
    localparam int unsigned H_RST = (SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : SIZE_RESET;

    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
    localparam logic [3:0]    K_LAST     = 4'(NB_COUNT);

    // register index is paddr[2]
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // sequencer states
    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_MODX   = 4'd2;
    localparam logic [3:0] ST_MODY   = 4'd3;
    localparam logic [3:0] ST_RDWAIT = 4'd4;
    localparam logic [3:0] ST_CNT    = 4'd5;
    localparam logic [3:0] ST_APPLY  = 4'd6;
    localparam logic [3:0] ST_CLEAR  = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    // row-major address with a fixed stride of MAX_WIDTH
    function automatic logic [AW-1:0] cell_addr(input logic [XA-1:0] x, input logic [YA-1:0] y);
        cell_addr = AW'(y) * ROW_STRIDE + AW'(x);
    endfunction

    // configuration registers
    logic [XW-1:0] grid_width_reg, grid_width_next;
    logic [YW-1:0] grid_height_reg, grid_height_next;

    // sequencer and item registers
    logic [3:0]            state_reg, state_next;
    logic [AW-1:0]         sweep_reg, sweep_next;
    logic [MW-1:0]         mod_reg, mod_next;
    logic [XA-1:0]         xm_reg, xm_next;
    logic [COORD_BITS-1:0] y_in_reg, y_in_next;
    logic [CELL_BITS-1:0]  tile_reg, tile_next;
    logic [1:0]            act_reg, act_next;
    logic [XA-1:0]         cx_reg, cx_next;
    logic [YA-1:0]         cy_reg, cy_next;
    logic [3:0]            k_reg, k_next;
    logic [2:0]            acc_reg, acc_next;
    logic                  ph_reg, ph_next;
    logic [CELL_BITS-1:0]  res_reg, res_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [CELL_BITS-1:0]  out_cell_reg, out_cell_next;
    logic [1:0]            out_act_reg, out_act_next;

    // ram ports
    logic                  grid_we, grid_re;
    logic [AW-1:0]         grid_waddr, grid_raddr;
    logic [CELL_BITS-1:0]  grid_wdata, grid_rdata;
    logic                  cnt_we, cnt_re;
    logic [AW-1:0]         cnt_waddr, cnt_raddr;
    logic [CNT_BITS-1:0]   cnt_wdata, cnt_rdata;

    // config write decode and clamp to 1..MAX
    logic                  cfg_wr;
    logic [CFG_BITS-1:0]   cfg_val;
    logic [XW-1:0]         width_clamped;
    logic [YW-1:0]         height_clamped;

    // neighbour walk
    logic [1:0]            dx_code, dy_code;
    logic [XA-1:0]         x_minus, x_plus, nx;
    logic [YA-1:0]         y_minus, y_plus, ny;
    logic                  last_x, last_y;
    logic [AW-1:0]         cur_addr;
    logic [CELL_BITS-1:0]  upd_cell;
    logic                  load_out;

    lcat_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (DEPTH)
    ) u_grid_ram (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .re    (grid_re),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    // per-cell live neighbour counts, rebuilt by every step before use
    lcat_ram #(
        .WIDTH (CNT_BITS),
        .DEPTH (DEPTH)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_val = pwdata[CFG_BITS-1:0];

    always_comb
    begin
        if (cfg_val == '0)
        begin
            width_clamped  = XW'(1);
            height_clamped = YW'(1);
        end
        else
        begin
            width_clamped  = (32'(cfg_val) > MAX_WIDTH)  ? XW'(MAX_WIDTH)  : XW'(cfg_val);
            height_clamped = (32'(cfg_val) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(cfg_val);
        end
    end

    always_comb
    begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_GRID_WIDTH:  grid_width_next  = width_clamped;
                REG_GRID_HEIGHT: grid_height_next = height_clamped;
                default:         grid_width_next  = grid_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_GRID_WIDTH:  prdata = 32'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = 32'(grid_height_reg);
            default:         prdata = '0;
        endcase
    end

    // wrapped neighbour coordinates of the current cell
    assign last_x  = (XW'(cx_reg) + XW'(1)) == grid_width_reg;
    assign last_y  = (YW'(cy_reg) + YW'(1)) == grid_height_reg;
    assign x_minus = (cx_reg == '0) ? XA'(grid_width_reg - XW'(1)) : cx_reg - XA'(1);
    assign y_minus = (cy_reg == '0) ? YA'(grid_height_reg - YW'(1)) : cy_reg - YA'(1);
    assign x_plus  = last_x ? '0 : cx_reg + XA'(1);
    assign y_plus  = last_y ? '0 : cy_reg + YA'(1);
    assign dx_code = NB_DX[{k_reg[2:0], 1'b0} +: 2];
    assign dy_code = NB_DY[{k_reg[2:0], 1'b0} +: 2];
    assign cur_addr = cell_addr(cx_reg, cy_reg);

    always_comb
    begin
        case (dx_code)
            OFS_MINUS: nx = x_minus;
            OFS_PLUS:  nx = x_plus;
            default:   nx = cx_reg;
        endcase
        case (dy_code)
            OFS_MINUS: ny = y_minus;
            OFS_PLUS:  ny = y_plus;
            default:   ny = cy_reg;
        endcase
    end

    // b3/s23 update; changed bits are only ever set
    always_comb
    begin
        upd_cell = grid_rdata;
        if (grid_rdata[ALIVE_POS])
        begin
            if (cnt_rdata < SURVIVE_MIN || cnt_rdata > SURVIVE_MAX)
            begin
                upd_cell = CELL_CHANGED;
            end
        end
        else if (cnt_rdata == BORN_COUNT)
        begin
            upd_cell = CELL_ALIVE_CHANGED;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        mod_next   = mod_reg;
        xm_next    = xm_reg;
        y_in_next  = y_in_reg;
        tile_next  = tile_reg;
        act_next   = act_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        ph_next    = ph_reg;
        res_next   = res_reg;
        load_out   = 1'b0;
        grid_we    = 1'b0;
        grid_waddr = '0;
        grid_wdata = '0;
        grid_re    = 1'b0;
        grid_raddr = '0;
        cnt_we     = 1'b0;
        cnt_waddr  = '0;
        cnt_wdata  = '0;
        cnt_re     = 1'b0;
        cnt_raddr  = '0;

        case (state_reg)
            ST_INIT:
            begin
                // post-reset sweep: every cell dead and not changed
                grid_we    = 1'b1;
                grid_waddr = sweep_reg;
                grid_wdata = CELL_DEAD;
                if (sweep_reg == LAST_ADDR)
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next  = s_tuser;
                    mod_next  = MW'(s_tdata[5:0]);
                    y_in_next = s_tdata[11:6];
                    tile_next = s_tdata[13:12];
                    res_next  = '0;
                    case (s_tuser)
                        ACT_STEP:
                        begin
                            cx_next    = '0;
                            cy_next    = '0;
                            k_next     = '0;
                            state_next = ST_CNT;
                        end
                        ACT_CLEAR:
                        begin
                            sweep_next = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_MODX;
                        end
                    endcase
                end
            end
            ST_MODX:
            begin
                // column modulo width by repeated subtraction
                if (mod_reg >= MW'(grid_width_reg))
                begin
                    mod_next = mod_reg - MW'(grid_width_reg);
                end
                else
                begin
                    xm_next    = mod_reg[XA-1:0];
                    mod_next   = MW'(y_in_reg);
                    state_next = ST_MODY;
                end
            end
            ST_MODY:
            begin
                if (mod_reg >= MW'(grid_height_reg))
                begin
                    mod_next = mod_reg - MW'(grid_height_reg);
                end
                else if (act_reg == ACT_WRITE)
                begin
                    grid_we    = 1'b1;
                    grid_waddr = cell_addr(xm_reg, mod_reg[YA-1:0]);
                    grid_wdata = tile_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    grid_re    = 1'b1;
                    grid_raddr = cell_addr(xm_reg, mod_reg[YA-1:0]);
                    state_next = ST_RDWAIT;
                end
            end
            ST_RDWAIT:
            begin
                res_next   = grid_rdata;
                state_next = ST_DONE;
            end
            ST_CNT:
            begin
                // issue neighbour reads k=0..7, sum each alive bit in the cycle after its read
                if (k_reg != K_LAST)
                begin
                    grid_re    = 1'b1;
                    grid_raddr = cell_addr(nx, ny);
                end
                if (k_reg == '0)
                begin
                    acc_next = '0;
                    k_next   = k_reg + 4'd1;
                end
                else if (k_reg != K_LAST)
                begin
                    acc_next = acc_reg + 3'(grid_rdata[ALIVE_POS]);
                    k_next   = k_reg + 4'd1;
                end
                else
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = cur_addr;
                    cnt_wdata = CNT_BITS'(acc_reg) + CNT_BITS'(grid_rdata[ALIVE_POS]);
                    k_next    = '0;
                    cx_next   = last_x ? '0 : cx_reg + XA'(1);
                    if (last_x)
                    begin
                        cy_next = last_y ? '0 : cy_reg + YA'(1);
                    end
                    if (last_x && last_y)
                    begin
                        ph_next    = 1'b0;
                        state_next = ST_APPLY;
                    end
                end
            end
            ST_APPLY:
            begin
                if (!ph_reg)
                begin
                    grid_re   = 1'b1;
                    grid_raddr = cur_addr;
                    cnt_re    = 1'b1;
                    cnt_raddr = cur_addr;
                    ph_next   = 1'b1;
                end
                else
                begin
                    grid_we    = 1'b1;
                    grid_waddr = cur_addr;
                    grid_wdata = upd_cell;
                    ph_next    = 1'b0;
                    cx_next    = last_x ? '0 : cx_reg + XA'(1);
                    if (last_x)
                    begin
                        cy_next = last_y ? '0 : cy_reg + YA'(1);
                    end
                    if (last_x && last_y)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CLEAR:
            begin
                // whole store, also cells outside the size in use
                grid_we    = 1'b1;
                grid_waddr = sweep_reg;
                grid_wdata = CELL_CHANGED;
                if (sweep_reg == LAST_ADDR)
                begin
                    sweep_next = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output beat register
    always_comb
    begin
        out_cell_next = out_cell_reg;
        out_act_next  = out_act_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_cell_next  = res_reg;
            out_act_next   = act_reg;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_cell_reg[CHANGED_POS], out_cell_reg[ALIVE_POS]};
    assign m_tuser  = out_act_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= XW'(W_RST);
            grid_height_reg <= YW'(H_RST);
            state_reg       <= ST_INIT;
            sweep_reg       <= '0;
            k_reg           <= '0;
            ph_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
            state_reg       <= state_next;
            sweep_reg       <= sweep_next;
            k_reg           <= k_next;
            ph_reg          <= ph_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // item payload, no reset needed
    always_ff @(posedge clk)
    begin
        mod_reg      <= mod_next;
        xm_reg       <= xm_next;
        y_in_reg     <= y_in_next;
        tile_reg     <= tile_next;
        act_reg      <= act_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        acc_reg      <= acc_next;
        res_reg      <= res_next;
        out_cell_reg <= out_cell_next;
        out_act_reg  <= out_act_next;
    end

    // one item at a time: after an accepted beat the input side closes
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // no input taken during the post-reset or clear sweeps
    a_sweep_closed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INIT || state_reg == ST_CLEAR |-> !s_tready)
        else $error("input ready during a grid sweep");

    // only read beats carry cell bits
    a_read_only_bits: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ACT_READ |-> m_tdata == 8'd0)
        else $error("cell bits on a non-read result");

    // a neighbour count never exceeds eight
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_we |-> cnt_wdata <= CNT_BITS'(NB_COUNT))
        else $error("neighbour count out of range");

endmodule
`default_nettype wire

// ===== sv/lcat_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module lcat_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire
